// ----- hdl/crc32_trailer_append_check_macros.svh -----
// Assertion macros shared by the CRC-32 trailer block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef CRC32_TRAILER_APPEND_CHECK_MACROS_SVH
`define CRC32_TRAILER_APPEND_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRC32TAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crc32 trailer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CRC32TAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crc32 trailer assertion failed");

`endif

// ----- hdl/crc32tac_pkg.sv -----
// Types, constants and the CRC byte update for the CRC-32 trailer block.
// No dependencies; used by crc32tac_step and crc32_trailer_append_check.
package crc32tac_pkg;

  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
  localparam int          TRAILER_BYTES = 4;
  localparam logic [2:0]  FILL_FULL     = 3'(TRAILER_BYTES);

  // Status codes reported on the frame_end result.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_SHORT    = 2'd2;

  // Hold window, entry 0 is the oldest byte and sits in the low bits.
  typedef logic [TRAILER_BYTES-1:0][7:0] win_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [1:0] status;
  } result_t;

  // Everything the per-byte logic hands back to the top level.
  typedef struct packed {
    logic        first_valid;
    result_t     first;
    logic        follow_valid;
    logic        follow_trailer;
    logic [31:0] follow_crc;
    logic [1:0]  follow_status;
    logic [31:0] crc_next;
    win_t        win_next;
    logic [2:0]  fill_next;
  } step_t;

  // Reflected CRC-32 update by one byte, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ----- hdl/crc32_trailer_append_check.sv -----
// CRC-32 trailer append and check: stream byte in, stream result out.
// Frame bytes arrive on the s_axis channel, one per request, tlast on the final byte.
// Results leave on m_axis: tdata is the byte, tlast marks the frame's last result,
// tuser carries byte_valid (bit 0) and status (bits 2:1; 0 ok, 1 mismatch, 2 short).
// Two APB registers: 0x0 check_enable, 0x4 direction (0 append, 1 check and strip).
// Write them only while no frame is in flight.
// A byte's result passes from the input register through the per-byte logic into the
// result register, which drives m_axis. Throughput is one byte per cycle while the
// receiver keeps up and no follow-up result is held, set by the combinational CRC
// byte update. The last byte of a frame in append mode yields five results and holds
// the input while the four trailer bytes go out; in check mode it may yield a payload
// byte and a status result, holding the input while a held status result waits.
// Reset clears the CRC, the window count, both registers and all valid flags.
// When the receiver stalls, the result register holds; the next byte that yields a
// result waits in the input register and s_axis_tready drops.
// Depends on crc32tac_pkg, crc32tac_step and the assertion macro header.
`include "crc32_trailer_append_check_macros.svh"

module crc32_trailer_append_check
  import crc32tac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // frame_last
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // frame_end
  output logic [2:0]  m_axis_tuser    // [0] byte_valid, [2:1] status
);

  localparam logic ADDR_ENABLE    = 1'b0;
  localparam logic ADDR_DIRECTION = 1'b1;

  logic        enable_q, direction_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic [31:0] crc_q;
  win_t        win_q;
  logic [2:0]  fill_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;
  logic        pend_valid_q, pend_valid_d;
  logic        pend_trailer_q, pend_trailer_d;
  logic [1:0]  pend_idx_q, pend_idx_d;
  logic [31:0] pend_crc_q, pend_crc_d;
  logic [1:0]  pend_status_q, pend_status_d;
  step_t       step;
  logic        cfg_write, out_free, in_consume, out_load;
  result_t     pend_res;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    unique case (paddr[2])
      ADDR_ENABLE:    prdata = {31'd0, enable_q};
      ADDR_DIRECTION: prdata = {31'd0, direction_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      direction_q <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == ADDR_ENABLE) begin
        enable_q <= pwdata[0];
      end else begin
        direction_q <= pwdata[0];
      end
    end
  end

  // Per-byte logic between the input register and the result register.
  crc32tac_step u_step (
    .enable_i     (enable_q),
    .direction_i  (direction_q),
    .crc_i        (crc_q),
    .win_i        (win_q),
    .fill_i       (fill_q),
    .data_byte_i  (in_byte_q),
    .frame_last_i (in_last_q),
    .step_o       (step)
  );

  // Handshake: a held follow-up result blocks the input register.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_consume    = in_valid_q && !pend_valid_q && (!step.first_valid || out_free);
  assign out_load      = pend_valid_q ? out_free : (in_consume && step.first_valid);
  assign s_axis_tready = !in_valid_q || in_consume;

  // Result offered by the follow-up register: trailer byte or status.
  always_comb begin
    if (pend_trailer_q) begin
      pend_res = '{pend_crc_q[8*pend_idx_q +: 8], 1'b1,
                   (pend_idx_q == 2'(TRAILER_BYTES - 1)), STATUS_OK};
    end else begin
      pend_res = '{8'd0, 1'b0, 1'b1, pend_status_q};
    end
  end

  // Next values of the result and follow-up registers.
  always_comb begin
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_d          = out_q;
    pend_valid_d   = pend_valid_q;
    pend_trailer_d = pend_trailer_q;
    pend_idx_d     = pend_idx_q;
    pend_crc_d     = pend_crc_q;
    pend_status_d  = pend_status_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      if (pend_valid_q) begin
        out_d = pend_res;
        if (pend_trailer_q && pend_idx_q != 2'(TRAILER_BYTES - 1)) begin
          pend_idx_d = pend_idx_q + 2'd1;
        end else begin
          pend_valid_d = 1'b0;
        end
      end else begin
        out_d          = step.first;
        pend_valid_d   = step.follow_valid;
        pend_trailer_d = step.follow_trailer;
        pend_idx_d     = '0;
        pend_crc_d     = step.follow_crc;
        pend_status_d  = step.follow_status;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      crc_q        <= '0;
      fill_q       <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (in_consume) begin
        crc_q  <= step.crc_next;
        fill_q <= step.fill_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (in_consume) begin
      win_q <= step.win_next;
    end
    out_q          <= out_d;
    pend_trailer_q <= pend_trailer_d;
    pend_idx_q     <= pend_idx_d;
    pend_crc_q     <= pend_crc_d;
    pend_status_q  <= pend_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.out_byte;
  assign m_axis_tlast  = out_q.frame_end;
  assign m_axis_tuser  = {out_q.status, out_q.byte_valid};

  // Checks on the internal sequencing.
  `CRC32TAC_ASSERT_SAME(a_pend_blocks_input, pend_valid_q, !in_consume)
  `CRC32TAC_ASSERT_SAME(a_fill_bounded, 1'b1, fill_q <= FILL_FULL)
  `CRC32TAC_ASSERT_SAME(a_status_at_end, m_axis_tvalid && m_axis_tuser[2:1] != STATUS_OK, m_axis_tlast)
  `CRC32TAC_ASSERT_NEXT(a_trailer_done, pend_valid_q && pend_trailer_q && out_load && pend_idx_q == 2'(TRAILER_BYTES - 1), !pend_valid_q && m_axis_tlast)
  `CRC32TAC_ASSERT_NEXT(a_pend_follows_load, !pend_valid_q && pend_valid_d, out_valid_q)

endmodule

// ----- hdl/crc32tac_step.sv -----
// Per-byte logic of the CRC-32 trailer block: next state and results for one byte.
// Depends on crc32tac_pkg.
module crc32tac_step
  import crc32tac_pkg::*;
(
  input  logic        enable_i,
  input  logic        direction_i,
  input  logic [31:0] crc_i,
  input  win_t        win_i,
  input  logic [2:0]  fill_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  output step_t       step_o
);

  logic        full;
  logic [7:0]  crc_in_byte;
  logic [31:0] crc_upd;
  logic [2:0]  fill_upd;
  logic [1:0]  st;

  // One shared byte update: new byte in append mode, oldest held byte in check mode.
  assign full        = (fill_i >= FILL_FULL);
  assign crc_in_byte = direction_i ? win_i[0] : data_byte_i;
  assign crc_upd     = crc_byte(crc_i, crc_in_byte);

  always_comb begin
    step_o          = '0;
    step_o.win_next = win_i;
    fill_upd        = fill_i;
    st              = STATUS_OK;
    if (!enable_i) begin
      // Pass-through; running state is dropped.
      step_o.first_valid = 1'b1;
      step_o.first       = '{data_byte_i, 1'b1, frame_last_i, STATUS_OK};
    end else if (!direction_i) begin
      // Append: byte passes, trailer follows the last byte.
      step_o.first_valid = 1'b1;
      step_o.first       = '{data_byte_i, 1'b1, 1'b0, STATUS_OK};
      if (frame_last_i) begin
        step_o.follow_valid   = 1'b1;
        step_o.follow_trailer = 1'b1;
        step_o.follow_crc     = crc_upd;
      end else begin
        step_o.crc_next = crc_upd;
      end
    end else begin
      // Check: delay the stream by four bytes.
      if (full) begin
        step_o.first_valid = 1'b1;
        step_o.first       = '{win_i[0], 1'b1, 1'b0, STATUS_OK};
        step_o.win_next    = {data_byte_i, win_i[3], win_i[2], win_i[1]};
        fill_upd           = FILL_FULL;
        step_o.crc_next    = crc_upd;
      end else begin
        step_o.win_next[fill_i[1:0]] = data_byte_i;
        fill_upd                     = fill_i + 3'd1;
        step_o.crc_next              = crc_i;
      end
      step_o.fill_next = fill_upd;
      if (frame_last_i) begin
        if (fill_upd < FILL_FULL) begin
          st = STATUS_SHORT;
        end else if (step_o.win_next != step_o.crc_next) begin
          st = STATUS_MISMATCH;
        end
        if (full) begin
          step_o.follow_valid  = 1'b1;
          step_o.follow_status = st;
        end else begin
          step_o.first_valid = 1'b1;
          step_o.first       = '{8'd0, 1'b0, 1'b1, st};
        end
        step_o.crc_next  = '0;
        step_o.fill_next = '0;
      end
    end
  end

endmodule
